/* src/far_pkg.sv */
// ----------------------------------------------------------------------------
// far_pkg
// shared types and codes for the fraction arithmetic unit
// ----------------------------------------------------------------------------
package far_pkg;

	localparam int unsigned NUM_W = 64;
	localparam int unsigned DEN_W = 62;

	localparam logic [2:0] MODE_ADD = 3'd0;
	localparam logic [2:0] MODE_SUB = 3'd1;
	localparam logic [2:0] MODE_MUL = 3'd2;
	localparam logic [2:0] MODE_DIV = 3'd3;
	localparam logic [2:0] MODE_RED = 3'd4;   // codes above this act as reduce too

	typedef struct packed {
		logic [2:0]         mode;
		logic signed [31:0] a_num;
		logic signed [31:0] a_den;
		logic signed [31:0] b_num;
		logic signed [31:0] b_den;
	} in_item_t;

	typedef struct packed {
		logic signed [63:0] result_num;
		logic [61:0]        result_den;
		logic               div_by_zero;
	} out_item_t;

	// datapath commands
	typedef enum logic [2:0] {
		CMD_NONE,
		CMD_LOAD,   // latch operands, cleaned up
		CMD_MUL,    // cross products
		CMD_COMB,   // combine products, fix sign
		CMD_GCD,    // one bit step of a euclid remainder, or its swap
		CMD_DIV     // one quotient bit of the two reducing divisions
	} cmd_t;

	typedef struct packed {
		logic gcd_done;   // remainder operand is zero
		logic rem_done;   // current remainder finished
		logic div_done;   // reducing division finished
		logic need_red;   // reduction applies and numerator nonzero
		logic g_gt1;      // gcd above one
	} status_t;

endpackage

/* src/far_datapath.sv */
// ----------------------------------------------------------------------------
// far_datapath
// operand cleanup, one multiplier, shift-subtract remainder/quotient unit
// ----------------------------------------------------------------------------
module far_datapath #(
	parameter int unsigned OPERAND_WIDTH = 32
) (
	input  logic                clk,
	input  far_pkg::cmd_t       cmd,
	input  logic                start_rem,
	input  logic                start_div,
	input  logic                div_sel,
	input  far_pkg::in_item_t   item,
	input  logic                auto_reduce,
	output far_pkg::status_t    status,
	output far_pkg::out_item_t  result
);
	localparam int unsigned OW = OPERAND_WIDTH;
	localparam logic signed [63:0] LIM = 64'sd1 <<< (OW - 1);

	function automatic logic signed [63:0] fix_op(input logic [31:0] raw, input logic one);
		logic signed [63:0] v;
		v = 64'(signed'(raw[OW-1:0]));
		if (v == -LIM) v = -(LIM - 64'sd1);
		if (one && v == 64'sd0) v = 64'sd1;
		return v;
	endfunction

	logic signed [63:0] an_q, ad_q, bn_q, bd_q;
	logic [2:0] mode_q;
	logic dz_q, red_q;
	logic [1:0] mcnt_q;
	logic signed [63:0] p0_q, p1_q, p2_q;
	logic signed [63:0] num_q;
	logic [63:0] den_q;
	// euclid / division unit
	logic [63:0] x_q, y_q;       // gcd operands
	logic [63:0] rem_q, quo_q, dvd_q, dvs_q;
	logic [6:0]  bit_q;
	logic        neg_q;

	// cleaned operands fit 32 signed bits, so one 32x32 multiplier serves
	logic signed [31:0] ma, mb;
	logic signed [63:0] mp;
	logic [64:0] trial;

	always_comb begin
		ma = an_q[31:0]; mb = bd_q[31:0];
		unique case (mcnt_q)
			2'd0: begin
				ma = an_q[31:0];
				mb = (mode_q == far_pkg::MODE_MUL) ? bn_q[31:0] : bd_q[31:0];
			end
			2'd1: begin ma = bn_q[31:0]; mb = ad_q[31:0]; end
			default: begin
				ma = ad_q[31:0];
				mb = (mode_q == far_pkg::MODE_DIV) ? bn_q[31:0] : bd_q[31:0];
			end
		endcase
		mp = 64'(ma) * 64'(mb);
	end

	assign trial = {rem_q, dvd_q[63]} - {1'b0, dvs_q};

	always_ff @(posedge clk) begin
		unique case (cmd)
			far_pkg::CMD_LOAD: begin
				mode_q <= (item.mode > far_pkg::MODE_DIV) ? far_pkg::MODE_RED : item.mode;
				an_q   <= fix_op(item.a_num, 1'b0);
				ad_q   <= fix_op(item.a_den, 1'b1);
				bn_q   <= fix_op(item.b_num, 1'b0);
				bd_q   <= fix_op(item.b_den, 1'b1);
				red_q  <= auto_reduce || item.mode > far_pkg::MODE_DIV;
				mcnt_q <= 2'd0;
			end
			far_pkg::CMD_MUL: begin
				unique case (mcnt_q)
					2'd0: p0_q <= mp;
					2'd1: p1_q <= mp;
					default: p2_q <= mp;
				endcase
				mcnt_q <= mcnt_q + 2'd1;
			end
			far_pkg::CMD_COMB: begin : comb
				logic signed [63:0] n, d;
				logic               dz;
				dz = 1'b0;
				unique case (mode_q)
					far_pkg::MODE_ADD: begin n = p0_q + p1_q; d = p2_q; end
					far_pkg::MODE_SUB: begin n = p0_q - p1_q; d = p2_q; end
					far_pkg::MODE_MUL: begin n = p0_q; d = p2_q; end
					far_pkg::MODE_DIV: begin
						n = p0_q; d = p2_q;
						if (bn_q == 64'sd0) begin n = 64'sd0; d = 64'sd1; dz = 1'b1; end
					end
					default: begin n = an_q; d = ad_q; end
				endcase
				if (d < 64'sd0) begin n = -n; d = -d; end
				if (n == 64'sd0) d = 64'sd1;
				dz_q  <= dz;
				num_q <= n;
				den_q <= d;
				x_q   <= (n < 64'sd0) ? 64'(-n) : 64'(n);
				y_q   <= d;
				neg_q <= n < 64'sd0;
			end
			far_pkg::CMD_GCD: begin
				// one remainder bit step of x mod y, swap at end
				if (start_rem) begin
					dvd_q <= x_q; dvs_q <= y_q; rem_q <= '0; bit_q <= 7'd0;
				end else if (bit_q != 7'd64) begin
					rem_q <= trial[64] ? {rem_q[62:0], dvd_q[63]} : trial[63:0];
					dvd_q <= {dvd_q[62:0], 1'b0};
					bit_q <= bit_q + 7'd1;
				end else begin
					x_q <= y_q; y_q <= rem_q; bit_q <= 7'd0;
					dvd_q <= y_q; dvs_q <= rem_q; rem_q <= '0;
				end
			end
			far_pkg::CMD_DIV: begin
				if (start_div) begin
					dvd_q <= div_sel ? den_q : (neg_q ? 64'(-num_q) : 64'(num_q));
					dvs_q <= x_q; rem_q <= '0; quo_q <= '0; bit_q <= 7'd0;
				end else if (bit_q != 7'd64) begin
					rem_q <= trial[64] ? {rem_q[62:0], dvd_q[63]} : trial[63:0];
					quo_q <= {quo_q[62:0], ~trial[64]};
					dvd_q <= {dvd_q[62:0], 1'b0};
					bit_q <= bit_q + 7'd1;
				end else if (div_sel) begin
					den_q <= quo_q;
				end else begin
					num_q <= neg_q ? -$signed(quo_q) : $signed(quo_q);
				end
			end
			default: ;
		endcase
	end

	assign status.gcd_done = (y_q == '0);
	assign status.rem_done = (bit_q == 7'd64);
	assign status.div_done = (bit_q == 7'd64);
	assign status.need_red = red_q && (num_q != 64'sd0);
	assign status.g_gt1    = (x_q > 64'd1);

	assign result.result_num  = num_q;
	assign result.result_den  = den_q[61:0];
	assign result.div_by_zero = dz_q;
endmodule

/* src/far_ctrl.sv */
// ----------------------------------------------------------------------------
// far_ctrl
// sequencer for load, multiply, euclid and the reducing divisions
// ----------------------------------------------------------------------------
module far_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  far_pkg::status_t  status,
	output far_pkg::cmd_t     cmd,
	output logic              start_rem,
	output logic              start_div,
	output logic              div_sel
);
	typedef enum logic [3:0] {
		ST_IDLE, ST_MUL0, ST_MUL1, ST_MUL2, ST_COMB, ST_CHK,
		ST_GCD_START, ST_GCD, ST_DIVN_START, ST_DIVN, ST_DIVD_START, ST_DIVD,
		ST_OUT
	} state_t;

	state_t state_q;
	logic   in_acc;

	assign in_ready = (state_q == ST_IDLE);
	assign in_acc   = in_valid && in_ready;
	assign out_valid = (state_q == ST_OUT);

	always_comb begin
		cmd = far_pkg::CMD_NONE; start_rem = 1'b0; start_div = 1'b0; div_sel = 1'b0;
		unique case (state_q)
			ST_IDLE: if (in_acc) cmd = far_pkg::CMD_LOAD;
			ST_MUL0, ST_MUL1, ST_MUL2: cmd = far_pkg::CMD_MUL;
			ST_COMB: cmd = far_pkg::CMD_COMB;
			ST_GCD_START: begin cmd = far_pkg::CMD_GCD; start_rem = 1'b1; end
			ST_GCD: cmd = far_pkg::CMD_GCD;
			ST_DIVN_START: begin cmd = far_pkg::CMD_DIV; start_div = 1'b1; end
			ST_DIVN: cmd = far_pkg::CMD_DIV;
			ST_DIVD_START: begin cmd = far_pkg::CMD_DIV; start_div = 1'b1; div_sel = 1'b1; end
			ST_DIVD: begin cmd = far_pkg::CMD_DIV; div_sel = 1'b1; end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: if (in_acc) state_q <= ST_MUL0;
				ST_MUL0: state_q <= ST_MUL1;
				ST_MUL1: state_q <= ST_MUL2;
				ST_MUL2: state_q <= ST_COMB;
				ST_COMB: state_q <= ST_CHK;
				ST_CHK: state_q <= status.need_red ? ST_GCD_START : ST_OUT;
				ST_GCD_START: state_q <= ST_GCD;
				ST_GCD: begin
					// after a swap step, stop when the new remainder is zero
					if (status.rem_done && status.gcd_done) state_q <= ST_GCD;
					if (!status.rem_done && status.gcd_done)
						state_q <= status.g_gt1 ? ST_DIVN_START : ST_OUT;
				end
				ST_DIVN_START: state_q <= ST_DIVN;
				ST_DIVN: if (status.div_done) state_q <= ST_DIVD_START;
				ST_DIVD_START: state_q <= ST_DIVD;
				ST_DIVD: if (status.div_done) state_q <= ST_OUT;
				ST_OUT: if (out_ready) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

/* src/fraction_arith_reduce_top.sv */
// sequence: load, multiply and combine when nothing is reduced; with reduction
//   also euclid remainder steps, plus the two 64-bit quotient divisions when the
//   gcd is above one
// throughput: one transaction at a time, next input taken after the result is
//   handed off and the sequencer is back in idle; set by the one-bit-per-cycle unit
// reset: arst_n asynchronous active low, clears the sequencer, auto_reduce to 1
// ----------------------------------------------------------------------------
// fraction_arith_reduce_top
// rational fraction add/sub/mul/div/reduce with gcd reduction
// ----------------------------------------------------------------------------
module fraction_arith_reduce_top #(
	parameter int unsigned OPERAND_WIDTH = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  far_pkg::in_item_t   in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output far_pkg::out_item_t  out_data,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic                cfg_data
);
	far_pkg::cmd_t    cmd;
	far_pkg::status_t status;
	logic start_rem, start_div, div_sel;
	logic auto_reduce_q;

	// config register, always writable
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			auto_reduce_q <= 1'b1;
		end else if (cfg_valid) begin
			auto_reduce_q <= cfg_data;
		end
	end

	// controller sequences one transaction through the datapath
	far_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_ready, .out_valid, .out_ready,
		.status, .cmd, .start_rem, .start_div, .div_sel
	);

	far_datapath #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_dp (
		.clk, .cmd, .start_rem, .start_div, .div_sel,
		.item(in_data), .auto_reduce(auto_reduce_q), .status, .result(out_data)
	);
endmodule

/* src/far_checker.sv */
// ----------------------------------------------------------------------------
// far_checker
// port-level checks of the fraction unit
// ----------------------------------------------------------------------------
module far_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input far_pkg::out_item_t out_data
);
	a_den_pos: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.result_den != '0) else $error("zero denominator");
	a_one_side: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid)) else $error("input open while result pending");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data)) else $error("result dropped");
	a_dz: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.div_by_zero |-> out_data.result_num == 0) else $error("dz value");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready) else $error("input open right after accept");
endmodule

bind fraction_arith_reduce_top far_checker u_chk (
	.clk, .arst_n, .in_valid, .in_ready, .out_valid, .out_ready, .out_data
);
